FILE: sv/rlepix_pkg.sv
// Shared types and constants for the run-length pixel image decoder.
// Used by the parser, the run queue, the emitter and the top level.
package rlepix_pkg;

   typedef enum logic [2:0] {
      PH_WIDTH_HI  = 3'd0,
      PH_WIDTH_LO  = 3'd1,
      PH_HEIGHT_HI = 3'd2,
      PH_HEIGHT_LO = 3'd3,
      PH_WORD_HI   = 3'd4,
      PH_WORD_LO   = 3'd5,
      PH_RUN_LEN   = 3'd6
   } phase_type;

   localparam logic [1:0] TMODE_NONE  = 2'd0;
   localparam logic [1:0] TMODE_BOTH  = 2'd1;
   localparam logic [1:0] TMODE_GREEN = 2'd2;

   localparam logic [15:0] KEY_MAGENTA = 16'hF81F;
   localparam logic [15:0] KEY_GREEN   = 16'h07E0;
   localparam int          RUN_FLAG_BIT = 5;

   // one placed run, as it travels from parser to emitter
   typedef struct packed {
      logic [15:0] color;
      logic [15:0] column;
      logic [15:0] row;
      logic [8:0]  length;
      logic        done;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: sv/rlepix_parser.sv
// Front part: parses the byte stream (header, pixel words, run bytes) and
// places each run in the image with row clipping. Depends on rlepix_pkg.
module rlepix_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic [7:0]          req_in_byte,
   output logic                run_push,
   output rlepix_pkg::run_type run_data
);

   rlepix_pkg::phase_type phase_ff, phase_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] word_ff, word_in;

   logic        accept;
   logic [8:0]  count;
   logic [15:0] room;
   logic        wrap;
   logic [8:0]  len;
   logic [16:0] row_next;
   logic        last_row;
   logic        done;
   logic [15:0] color;
   logic        emit;

   assign accept   = req_valid & req_ready;
   assign count    = (phase_ff == rlepix_pkg::PH_RUN_LEN) ? ({1'b0, req_in_byte} + 9'd1) : 9'd1;
   // room is at least one while a run is being placed
   assign room     = width_ff - col_ff;
   assign wrap     = {7'd0, count} >= room;
   assign len      = wrap ? room[8:0] : count;
   assign row_next = {1'b0, row_ff} + 17'd1;
   assign last_row = row_next == {1'b0, height_ff};
   assign done     = wrap & last_row;
   assign color    = (phase_ff == rlepix_pkg::PH_RUN_LEN) ? word_ff
                                                          : {word_ff[15:8], req_in_byte};
   assign emit     = ((phase_ff == rlepix_pkg::PH_WORD_LO) &
                      !req_in_byte[rlepix_pkg::RUN_FLAG_BIT]) |
                     (phase_ff == rlepix_pkg::PH_RUN_LEN);

   assign run_push        = accept & emit;
   assign run_data.color  = color;
   assign run_data.column = col_ff;
   assign run_data.row    = row_ff;
   assign run_data.length = len;
   assign run_data.done   = done;

   always_comb begin
      phase_in  = phase_ff;
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      word_in   = word_ff;
      if (accept) begin
         unique case (phase_ff)
            rlepix_pkg::PH_WIDTH_HI: begin
               width_in = {req_in_byte, 8'd0};
               phase_in = rlepix_pkg::PH_WIDTH_LO;
            end
            rlepix_pkg::PH_WIDTH_LO: begin
               width_in = {width_ff[15:8], req_in_byte};
               phase_in = rlepix_pkg::PH_HEIGHT_HI;
            end
            rlepix_pkg::PH_HEIGHT_HI: begin
               height_in = {req_in_byte, 8'd0};
               phase_in  = rlepix_pkg::PH_HEIGHT_LO;
            end
            rlepix_pkg::PH_HEIGHT_LO: begin
               height_in = {height_ff[15:8], req_in_byte};
               col_in    = 16'd0;
               row_in    = 16'd0;
               // empty image: straight back to a new header
               if (width_ff == 16'd0 || height_in == 16'd0) begin
                  phase_in = rlepix_pkg::PH_WIDTH_HI;
               end else begin
                  phase_in = rlepix_pkg::PH_WORD_HI;
               end
            end
            rlepix_pkg::PH_WORD_HI: begin
               word_in  = {req_in_byte, 8'd0};
               phase_in = rlepix_pkg::PH_WORD_LO;
            end
            rlepix_pkg::PH_WORD_LO: begin
               word_in = {word_ff[15:8], req_in_byte};
               if (req_in_byte[rlepix_pkg::RUN_FLAG_BIT]) begin
                  word_in[rlepix_pkg::RUN_FLAG_BIT] = 1'b0;
                  phase_in = rlepix_pkg::PH_RUN_LEN;
               end
            end
            rlepix_pkg::PH_RUN_LEN: begin
            end
            default: begin
               phase_in = rlepix_pkg::PH_WIDTH_HI;
            end
         endcase
         if (emit) begin
            if (wrap) begin
               col_in = 16'd0;
               row_in = last_row ? 16'd0 : row_next[15:0];
            end else begin
               col_in = col_ff + {7'd0, count};
            end
            phase_in = done ? rlepix_pkg::PH_WIDTH_HI : rlepix_pkg::PH_WORD_HI;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= rlepix_pkg::PH_WIDTH_HI;
         width_ff  <= 16'd0;
         height_ff <= 16'd0;
         col_ff    <= 16'd0;
         row_ff    <= 16'd0;
         word_ff   <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         word_ff   <= word_in;
      end
   end

endmodule

FILE: sv/rlepix_queue.sv
// Short run queue between parser and emitter, a circular buffer of registers.
// Depends on rlepix_pkg for the run and status types.
module rlepix_queue #(
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rlepix_pkg::run_type          push_data,
   input  logic                         pop,
   output rlepix_pkg::run_type          pop_data,
   output rlepix_pkg::queue_status_type status
);

   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntWidth = $clog2(DEPTH + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   rlepix_pkg::run_type slot_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign status.full  = cnt_ff == FullCnt;
   assign status.empty = cnt_ff == '0;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/rlepix_emitter.sv
// Back part: holds the transparency mode, keys each run's colour and drives
// the result register. Depends on rlepix_pkg.
module rlepix_emitter (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_wdata,
   input  rlepix_pkg::queue_status_type q_status,
   input  rlepix_pkg::run_type          q_data,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [15:0]                  rsp_pixel_color,
   output logic [15:0]                  rsp_start_column,
   output logic [15:0]                  rsp_row_index,
   output logic [8:0]                   rsp_run_length,
   output logic                         rsp_is_transparent,
   output logic                         rsp_image_done
);

   logic [1:0]          mode_ff;
   logic                valid_ff;
   rlepix_pkg::run_type run_ff;
   logic                transp_ff;
   logic                transp;

   always_comb begin
      unique case (mode_ff)
         rlepix_pkg::TMODE_BOTH:  transp = (q_data.color == rlepix_pkg::KEY_MAGENTA) ||
                                           (q_data.color == rlepix_pkg::KEY_GREEN);
         rlepix_pkg::TMODE_GREEN: transp = q_data.color == rlepix_pkg::KEY_GREEN;
         default:                 transp = 1'b0;
      endcase
   end

   // take a run when the result register is empty or its beat is taken
   assign q_pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= rlepix_pkg::TMODE_NONE;
         valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mode_ff <= csr_wdata;
         end
         if (q_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         run_ff    <= q_data;
         transp_ff <= transp;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_pixel_color    = run_ff.color;
   assign rsp_start_column   = run_ff.column;
   assign rsp_row_index      = run_ff.row;
   assign rsp_run_length     = run_ff.length;
   assign rsp_is_transparent = transp_ff;
   assign rsp_image_done     = run_ff.done;

endmodule

FILE: sv/rle_pixel_image_decoder.sv
// Run-length pixel image decoder: one stream byte per cycle, one beat per run.
// Throughput: one byte accepted every cycle while the run queue has room; the result
// register takes a new run each time its beat is taken. A stalled result side fills
// the queue and holds off input. Each run goes from the parser into a queue slot
// register, then into the result register, where its beat is presented.
// Reset (synchronous): parser expects a width header, queue and result empty,
// transparency mode off.
module rle_pixel_image_decoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_color,
   output logic [15:0] rsp_start_column,
   output logic [15:0] rsp_row_index,
   output logic [8:0]  rsp_run_length,
   output logic        rsp_is_transparent,
   output logic        rsp_image_done,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata
);

   logic                         run_push;
   rlepix_pkg::run_type          run_data;
   logic                         q_pop;
   rlepix_pkg::run_type          q_data;
   rlepix_pkg::queue_status_type q_status;

   assign req_ready = !q_status.full;

   rlepix_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .run_push    (run_push),
      .run_data    (run_data)
   );

   rlepix_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (run_push),
      .push_data (run_data),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   rlepix_emitter u_emitter (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .q_status           (q_status),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_pixel_color    (rsp_pixel_color),
      .rsp_start_column   (rsp_start_column),
      .rsp_row_index      (rsp_row_index),
      .rsp_run_length     (rsp_run_length),
      .rsp_is_transparent (rsp_is_transparent),
      .rsp_image_done     (rsp_image_done)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      run_push |-> !q_status.full)
      else $error("run pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_status.empty)
      else $error("run popped from an empty queue");

   a_len_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_run_length != 9'd0))
      else $error("zero-length run beat");

   a_transp_key: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_transparent) |->
         (rsp_pixel_color == rlepix_pkg::KEY_MAGENTA ||
          rsp_pixel_color == rlepix_pkg::KEY_GREEN))
      else $error("transparent beat with a non-key colour");

endmodule
